### src/ibb_pkg.sv
// ----------------------------------------------------------------------------
// ibb_pkg
// Types and constants shared by the I2C bit engine and its channels.
// ----------------------------------------------------------------------------
package ibb_pkg;

	localparam int unsigned BITS_PER_BYTE = 8;
	localparam int unsigned BIT_W = 4;
	localparam int unsigned DLY_W = 20;
	localparam int unsigned CFG_W = 16;

	localparam logic [2:0] MODE_START     = 3'd1;
	localparam logic [2:0] MODE_STOP      = 3'd2;
	localparam logic [2:0] MODE_WRITE     = 3'd3;
	localparam logic [2:0] MODE_READ_ACK  = 3'd4;
	localparam logic [2:0] MODE_READ_NACK = 3'd5;
	localparam logic [2:0] MODE_WAIT_ACK  = 3'd6;

	localparam logic REG_DELAY_UNIT    = 1'b0;
	localparam logic REG_TIMEOUT_LIMIT = 1'b1;

	localparam logic [CFG_W-1:0] DELAY_UNIT_RST    = 16'd1;
	localparam logic [CFG_W-1:0] TIMEOUT_LIMIT_RST = 16'd250;

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_ST_B,
		PH_ST_C,
		PH_SP_B,
		PH_SP_END,
		PH_WR_HI,
		PH_WR_LO,
		PH_WR_NEXT,
		PH_RD_HI,
		PH_RD_NEXT,
		PH_AK_SDA,
		PH_AK_HI,
		PH_AK_LO,
		PH_WA_HI,
		PH_WA_POLL
	} phase_t;

	typedef struct packed {
		logic [2:0] mode;
		logic [7:0] data_byte;
		logic       sda_in;
	} req_t;

	typedef struct packed {
		logic       scl_out;
		logic       sda_out;
		logic       busy_res;
		logic       done_res;
		logic [7:0] read_data;
		logic       ack_timeout;
	} rsp_t;

	typedef struct packed {
		logic             index;
		logic [CFG_W-1:0] value;
	} cfg_t;

	typedef struct packed {
		logic [CFG_W-1:0] delay_unit;
		logic [CFG_W-1:0] timeout_limit;
	} eng_cfg_t;

endpackage

### src/ibb_chan_if.sv
// ----------------------------------------------------------------------------
// ibb_chan_if
// Valid/ready channel carrying one payload of a given type.
// ----------------------------------------------------------------------------
interface ibb_chan_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

### src/ibb_engine.sv
// ----------------------------------------------------------------------------
// ibb_engine
// Pin sequencer state and next-tick logic; state advances on each request.
// ----------------------------------------------------------------------------
module ibb_engine (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  ibb_pkg::req_t    req_data,
	input  ibb_pkg::eng_cfg_t cfg,
	output ibb_pkg::rsp_t    rsp_next
);

	ibb_pkg::phase_t                 phase_q, phase_d;
	logic [ibb_pkg::BIT_W-1:0]       bit_q, bit_d;
	logic [7:0]                      shift_q, shift_d;
	logic [ibb_pkg::DLY_W-1:0]       dly_q, dly_d;
	logic [ibb_pkg::CFG_W-1:0]       poll_q, poll_d;
	logic                            scl_q, scl_d;
	logic                            sda_q, sda_d;
	logic [7:0]                      last_q, last_d;
	logic                            rack_q, rack_d;
	logic                            tmo_q, tmo_d;
	logic                            done;
	logic [ibb_pkg::CFG_W:0]         poll_inc;
	logic                            poll_over;
	logic                            dly_zero;
	logic [ibb_pkg::DLY_W-1:0]       dly1, dly2, dly4;

	// ticks minus one for 1, 2 and 4 microseconds
	function automatic logic [ibb_pkg::DLY_W-1:0] ticks(
		input logic [ibb_pkg::CFG_W-1:0] unit,
		input logic [1:0]                sh
	);
		logic [ibb_pkg::DLY_W-1:0] u;
		u = (unit == '0) ? ibb_pkg::DLY_W'(1) : ibb_pkg::DLY_W'(unit);
		return (u << sh) - ibb_pkg::DLY_W'(1);
	endfunction

	assign dly1      = ticks(cfg.delay_unit, 2'd0);
	assign dly2      = ticks(cfg.delay_unit, 2'd1);
	assign dly4      = ticks(cfg.delay_unit, 2'd2);
	assign dly_zero  = (dly_q == '0);
	assign poll_inc  = {1'b0, poll_q} + 1'b1;
	assign poll_over = poll_inc > {1'b0, cfg.timeout_limit};

	// next phase
	always_comb begin
		phase_d = phase_q;
		if (phase_q == ibb_pkg::PH_IDLE) begin
			unique case (req_data.mode)
				ibb_pkg::MODE_START:     phase_d = ibb_pkg::PH_ST_B;
				ibb_pkg::MODE_STOP:      phase_d = ibb_pkg::PH_SP_B;
				ibb_pkg::MODE_WRITE:     phase_d = ibb_pkg::PH_WR_HI;
				ibb_pkg::MODE_READ_ACK,
				ibb_pkg::MODE_READ_NACK: phase_d = ibb_pkg::PH_RD_HI;
				ibb_pkg::MODE_WAIT_ACK:  phase_d = ibb_pkg::PH_WA_HI;
				default:                 phase_d = ibb_pkg::PH_IDLE;
			endcase
		end else if (dly_zero) begin
			unique case (phase_q)
				ibb_pkg::PH_ST_B:    phase_d = ibb_pkg::PH_ST_C;
				ibb_pkg::PH_SP_B:    phase_d = ibb_pkg::PH_SP_END;
				ibb_pkg::PH_WR_HI:   phase_d = ibb_pkg::PH_WR_LO;
				ibb_pkg::PH_WR_LO:   phase_d = ibb_pkg::PH_WR_NEXT;
				ibb_pkg::PH_WR_NEXT: begin
					phase_d = (bit_q >= ibb_pkg::BIT_W'(ibb_pkg::BITS_PER_BYTE)) ?
						ibb_pkg::PH_IDLE : ibb_pkg::PH_WR_HI;
				end
				ibb_pkg::PH_RD_HI:   phase_d = ibb_pkg::PH_RD_NEXT;
				ibb_pkg::PH_RD_NEXT: begin
					phase_d = (bit_q >= ibb_pkg::BIT_W'(ibb_pkg::BITS_PER_BYTE)) ?
						ibb_pkg::PH_AK_SDA : ibb_pkg::PH_RD_HI;
				end
				ibb_pkg::PH_AK_SDA:  phase_d = ibb_pkg::PH_AK_HI;
				ibb_pkg::PH_AK_HI:   phase_d = ibb_pkg::PH_AK_LO;
				ibb_pkg::PH_WA_HI:   phase_d = ibb_pkg::PH_WA_POLL;
				ibb_pkg::PH_WA_POLL: begin
					if (!req_data.sda_in) begin
						phase_d = ibb_pkg::PH_IDLE;
					end else if (poll_over) begin
						phase_d = ibb_pkg::PH_SP_B;
					end
				end
				default:             phase_d = ibb_pkg::PH_IDLE;
			endcase
		end
	end

	// pins, counters and flags
	always_comb begin
		bit_d   = bit_q;
		shift_d = shift_q;
		dly_d   = dly_q;
		poll_d  = poll_q;
		scl_d   = scl_q;
		sda_d   = sda_q;
		last_d  = last_q;
		rack_d  = rack_q;
		tmo_d   = tmo_q;
		done    = 1'b0;
		if (phase_q == ibb_pkg::PH_IDLE) begin
			unique case (req_data.mode)
				ibb_pkg::MODE_START: begin
					sda_d = 1'b1;
					scl_d = 1'b1;
					dly_d = dly4;
				end
				ibb_pkg::MODE_STOP: begin
					scl_d = 1'b0;
					sda_d = 1'b0;
					dly_d = dly4;
				end
				ibb_pkg::MODE_WRITE: begin
					shift_d = req_data.data_byte;
					bit_d   = '0;
					sda_d   = req_data.data_byte[7];
					dly_d   = dly2;
				end
				ibb_pkg::MODE_READ_ACK,
				ibb_pkg::MODE_READ_NACK: begin
					rack_d  = (req_data.mode == ibb_pkg::MODE_READ_ACK);
					shift_d = '0;
					bit_d   = '0;
					sda_d   = 1'b1;
					scl_d   = 1'b0;
					dly_d   = dly2;
				end
				ibb_pkg::MODE_WAIT_ACK: begin
					tmo_d  = 1'b0;
					poll_d = '0;
					sda_d  = 1'b1;
					dly_d  = dly1;
				end
				default: begin
				end
			endcase
		end else if (!dly_zero) begin
			dly_d = dly_q - 1'b1;
		end else begin
			unique case (phase_q)
				ibb_pkg::PH_ST_B: begin
					sda_d = 1'b0;
					dly_d = dly4;
				end
				ibb_pkg::PH_ST_C: begin
					scl_d = 1'b0;
					done  = 1'b1;
				end
				ibb_pkg::PH_SP_B: begin
					scl_d = 1'b1;
					sda_d = 1'b1;
					dly_d = dly4;
				end
				ibb_pkg::PH_SP_END: done = 1'b1;
				ibb_pkg::PH_WR_HI: begin
					scl_d = 1'b1;
					dly_d = dly2;
				end
				ibb_pkg::PH_WR_LO: begin
					scl_d = 1'b0;
					if (bit_q == ibb_pkg::BIT_W'(ibb_pkg::BITS_PER_BYTE - 1)) begin
						sda_d = 1'b1;
					end
					shift_d = {shift_q[6:0], 1'b0};
					bit_d   = bit_q + 1'b1;
					dly_d   = dly4;
				end
				ibb_pkg::PH_WR_NEXT: begin
					if (bit_q >= ibb_pkg::BIT_W'(ibb_pkg::BITS_PER_BYTE)) begin
						done = 1'b1;
					end else begin
						sda_d = shift_q[7];
						dly_d = dly2;
					end
				end
				ibb_pkg::PH_RD_HI: begin
					scl_d   = 1'b1;
					shift_d = {shift_q[6:0], req_data.sda_in};
					bit_d   = bit_q + 1'b1;
					dly_d   = dly1;
				end
				ibb_pkg::PH_RD_NEXT: begin
					scl_d = 1'b0;
					dly_d = dly2;
					if (bit_q >= ibb_pkg::BIT_W'(ibb_pkg::BITS_PER_BYTE)) begin
						last_d = shift_q;
					end
				end
				ibb_pkg::PH_AK_SDA: begin
					sda_d = !rack_q;
					dly_d = dly2;
				end
				ibb_pkg::PH_AK_HI: begin
					scl_d = 1'b1;
					dly_d = dly2;
				end
				ibb_pkg::PH_AK_LO: begin
					scl_d = 1'b0;
					done  = 1'b1;
				end
				ibb_pkg::PH_WA_HI: begin
					scl_d = 1'b1;
					dly_d = dly1;
				end
				ibb_pkg::PH_WA_POLL: begin
					if (!req_data.sda_in) begin
						scl_d = 1'b0;
						done  = 1'b1;
					end else if (poll_over) begin
						// timeout: flag it and run a stop
						tmo_d = 1'b1;
						scl_d = 1'b0;
						sda_d = 1'b0;
						dly_d = dly4;
					end else begin
						poll_d = poll_inc[ibb_pkg::CFG_W-1:0];
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= ibb_pkg::PH_IDLE;
			bit_q   <= '0;
			shift_q <= '0;
			dly_q   <= '0;
			poll_q  <= '0;
			scl_q   <= 1'b1;
			sda_q   <= 1'b1;
			last_q  <= '0;
			rack_q  <= 1'b0;
			tmo_q   <= 1'b0;
		end else if (step) begin
			phase_q <= phase_d;
			bit_q   <= bit_d;
			shift_q <= shift_d;
			dly_q   <= dly_d;
			poll_q  <= poll_d;
			scl_q   <= scl_d;
			sda_q   <= sda_d;
			last_q  <= last_d;
			rack_q  <= rack_d;
			tmo_q   <= tmo_d;
		end
	end

	always_comb begin
		rsp_next.scl_out     = scl_d;
		rsp_next.sda_out     = sda_d;
		rsp_next.busy_res    = (phase_d != ibb_pkg::PH_IDLE);
		rsp_next.done_res    = done;
		rsp_next.read_data   = last_d;
		rsp_next.ack_timeout = tmo_d;
	end

endmodule

### src/i2c_bit_bang_master.sv
// ----------------------------------------------------------------------------
// i2c_bit_bang_master
// I2C master pin engine; one request is one time tick of the bus sequencer.
//
//   channel  dir  payload
//   req      in   mode, data_byte, sda_in
//   rsp      out  scl_out, sda_out, busy_res, done_res, read_data, ack_timeout
//   cfg      in   index (0 delay_unit, 1 timeout_limit), value
//
// One request per clock while the result is not stalled; its result is registered and valid the next cycle.
// The engine state and the result register advance together, so the rate is
// set by that single register stage.
// A stalled result holds the request side off; cfg is always ready.
// Reset clears the engine to idle with both lines released.
// ----------------------------------------------------------------------------
module i2c_bit_bang_master (
	input logic       clk,
	input logic       arst_n,
	ibb_chan_if.sink   req,
	ibb_chan_if.source rsp,
	ibb_chan_if.sink   cfg
);

	ibb_pkg::eng_cfg_t cfg_q;
	ibb_pkg::rsp_t     rsp_next;
	ibb_pkg::rsp_t     rsp_q;
	logic              vld_q;
	logic              step;

	assign req.ready = !vld_q || rsp.ready;
	assign step      = req.valid && req.ready;
	assign cfg.ready = 1'b1;
	assign rsp.valid = vld_q;
	assign rsp.data  = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.delay_unit    <= ibb_pkg::DELAY_UNIT_RST;
			cfg_q.timeout_limit <= ibb_pkg::TIMEOUT_LIMIT_RST;
		end else if (cfg.valid) begin
			unique case (cfg.data.index)
				ibb_pkg::REG_DELAY_UNIT:    cfg_q.delay_unit    <= cfg.data.value;
				ibb_pkg::REG_TIMEOUT_LIMIT: cfg_q.timeout_limit <= cfg.data.value;
				default: begin
				end
			endcase
		end
	end

	ibb_engine u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.req_data (req.data),
		.cfg      (cfg_q),
		.rsp_next (rsp_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (step) begin
			vld_q <= 1'b1;
		end else if (rsp.ready) begin
			vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			rsp_q <= rsp_next;
		end
	end

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !(rsp.data.done_res && rsp.data.busy_res))
		else $error("done and busy together");

	a_req_gives_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> rsp.valid)
		else $error("request without result");

	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.ready) |-> !req.ready)
		else $error("request taken while result stalled");

endmodule

### tb/sv/tb_i2c_bit_bang_master.sv
// ----------------------------------------------------------------------------
// tb_i2c_bit_bang_master
// Drives tick requests into the I2C bit engine and checks every registered
// pin result against an in-bench copy of the engine sequencer. Commands are
// issued only once the engine is idle, and filler ticks cover each delay.
// Register writes happen between phases, covering a zero delay unit and a
// zero or one timeout limit. Both channel sides idle in random bursts, except in the last random stretch.
// ----------------------------------------------------------------------------
module tb_i2c_bit_bang_master;

	localparam logic [2:0] MODE_NONE   = 3'd0;
	localparam logic [2:0] MODE_UNUSED = 3'd7;

	typedef enum {SDA_RAND, SDA_HIGH, SDA_LOW} sda_pol_t;

	logic clk = 1'b0;
	logic arst_n;

	always #10 clk = ~clk;

	ibb_chan_if #(.T(ibb_pkg::req_t)) req_ch ();
	ibb_chan_if #(.T(ibb_pkg::rsp_t)) rsp_ch ();
	ibb_chan_if #(.T(ibb_pkg::cfg_t)) cfg_ch ();

	i2c_bit_bang_master dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	ibb_pkg::req_t tick_q[$];
	ibb_pkg::rsp_t pins_due[$];
	int unsigned   n_err = 0;
	int unsigned   n_sent = 0;
	bit            idling = 1'b1;

	// engine copy
	ibb_pkg::phase_t                m_ph;
	logic [ibb_pkg::BIT_W-1:0]      m_bidx;
	logic [7:0]                     m_sreg;
	logic [ibb_pkg::DLY_W-1:0]      m_dcnt;
	logic [15:0]                    m_pcnt;
	logic                           m_scl;
	logic                           m_sda;
	logic [7:0]                     m_last;
	logic                           m_rd_ack;
	logic                           m_to;
	logic [ibb_pkg::CFG_W-1:0]      m_du;
	logic [ibb_pkg::CFG_W-1:0]      m_tl;

	function automatic logic [ibb_pkg::DLY_W-1:0] us_ticks(input int unsigned us);
		int unsigned u;
		u = (m_du == 0) ? 1 : m_du;
		return ibb_pkg::DLY_W'(us * u - 1);
	endfunction

	function automatic void stop_seq();
		m_scl = 1'b0;
		m_sda = 1'b0;
		m_dcnt = us_ticks(4);
		m_ph = ibb_pkg::PH_SP_B;
	endfunction

	function automatic ibb_pkg::rsp_t engine_step(input ibb_pkg::req_t r);
		logic          done;
		ibb_pkg::rsp_t o;
		done = 1'b0;
		if (m_ph == ibb_pkg::PH_IDLE) begin
			case (r.mode)
				ibb_pkg::MODE_START: begin
					m_sda = 1'b1; m_scl = 1'b1; m_dcnt = us_ticks(4);
					m_ph = ibb_pkg::PH_ST_B;
				end
				ibb_pkg::MODE_STOP: stop_seq();
				ibb_pkg::MODE_WRITE: begin
					m_sreg = r.data_byte; m_bidx = '0; m_sda = r.data_byte[7];
					m_dcnt = us_ticks(2); m_ph = ibb_pkg::PH_WR_HI;
				end
				ibb_pkg::MODE_READ_ACK, ibb_pkg::MODE_READ_NACK: begin
					m_rd_ack = (r.mode == ibb_pkg::MODE_READ_ACK);
					m_sreg = '0; m_bidx = '0; m_sda = 1'b1; m_scl = 1'b0;
					m_dcnt = us_ticks(2); m_ph = ibb_pkg::PH_RD_HI;
				end
				ibb_pkg::MODE_WAIT_ACK: begin
					m_to = 1'b0; m_pcnt = '0; m_sda = 1'b1;
					m_dcnt = us_ticks(1); m_ph = ibb_pkg::PH_WA_HI;
				end
				default: ;
			endcase
		end else if (m_dcnt != 0) begin
			m_dcnt--;
		end else begin
			case (m_ph)
				ibb_pkg::PH_ST_B: begin
					m_sda = 1'b0; m_dcnt = us_ticks(4); m_ph = ibb_pkg::PH_ST_C;
				end
				ibb_pkg::PH_ST_C: begin
					m_scl = 1'b0; m_ph = ibb_pkg::PH_IDLE; done = 1'b1;
				end
				ibb_pkg::PH_SP_B: begin
					m_scl = 1'b1; m_sda = 1'b1; m_dcnt = us_ticks(4);
					m_ph = ibb_pkg::PH_SP_END;
				end
				ibb_pkg::PH_SP_END: begin
					m_ph = ibb_pkg::PH_IDLE; done = 1'b1;
				end
				ibb_pkg::PH_WR_HI: begin
					m_scl = 1'b1; m_dcnt = us_ticks(2); m_ph = ibb_pkg::PH_WR_LO;
				end
				ibb_pkg::PH_WR_LO: begin
					m_scl = 1'b0;
					if (m_bidx == ibb_pkg::BITS_PER_BYTE - 1)
						m_sda = 1'b1;
					m_sreg = {m_sreg[6:0], 1'b0};
					m_bidx = m_bidx + 1'b1;
					m_dcnt = us_ticks(4); m_ph = ibb_pkg::PH_WR_NEXT;
				end
				ibb_pkg::PH_WR_NEXT: begin
					if (m_bidx >= ibb_pkg::BITS_PER_BYTE) begin
						m_ph = ibb_pkg::PH_IDLE; done = 1'b1;
					end else begin
						m_sda = m_sreg[7]; m_dcnt = us_ticks(2);
						m_ph = ibb_pkg::PH_WR_HI;
					end
				end
				ibb_pkg::PH_RD_HI: begin
					m_scl = 1'b1;
					m_sreg = {m_sreg[6:0], r.sda_in};
					m_bidx = m_bidx + 1'b1;
					m_dcnt = us_ticks(1); m_ph = ibb_pkg::PH_RD_NEXT;
				end
				ibb_pkg::PH_RD_NEXT: begin
					m_scl = 1'b0; m_dcnt = us_ticks(2);
					if (m_bidx >= ibb_pkg::BITS_PER_BYTE) begin
						m_last = m_sreg; m_ph = ibb_pkg::PH_AK_SDA;
					end else begin
						m_ph = ibb_pkg::PH_RD_HI;
					end
				end
				ibb_pkg::PH_AK_SDA: begin
					m_sda = !m_rd_ack; m_dcnt = us_ticks(2); m_ph = ibb_pkg::PH_AK_HI;
				end
				ibb_pkg::PH_AK_HI: begin
					m_scl = 1'b1; m_dcnt = us_ticks(2); m_ph = ibb_pkg::PH_AK_LO;
				end
				ibb_pkg::PH_AK_LO: begin
					m_scl = 1'b0; m_ph = ibb_pkg::PH_IDLE; done = 1'b1;
				end
				ibb_pkg::PH_WA_HI: begin
					m_scl = 1'b1; m_dcnt = us_ticks(1); m_ph = ibb_pkg::PH_WA_POLL;
				end
				ibb_pkg::PH_WA_POLL: begin
					if (!r.sda_in) begin
						m_scl = 1'b0; m_ph = ibb_pkg::PH_IDLE; done = 1'b1;
					end else if ((32'(m_pcnt) + 1) > 32'(m_tl)) begin
						m_to = 1'b1;
						stop_seq();
					end else begin
						m_pcnt = m_pcnt + 1'b1;
					end
				end
				default: m_ph = ibb_pkg::PH_IDLE;
			endcase
		end
		o.scl_out     = m_scl;
		o.sda_out     = m_sda;
		o.busy_res    = (m_ph != ibb_pkg::PH_IDLE);
		o.done_res    = done;
		o.read_data   = m_last;
		o.ack_timeout = m_to;
		return o;
	endfunction

	// request driver
	int unsigned   gap_left;
	ibb_pkg::req_t acc;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			gap_left = 0;
		end else if (!(req_ch.valid && !req_ch.ready)) begin
			if (req_ch.valid) begin
				acc = tick_q.pop_front();
				pins_due.push_back(engine_step(acc));
			end
			if (gap_left != 0) begin
				gap_left--;
				req_ch.valid <= 1'b0;
			end else if (tick_q.size() != 0 && idling && $urandom_range(0, 7) == 0) begin
				gap_left = $urandom_range(0, 9);
				req_ch.valid <= 1'b0;
			end else if (tick_q.size() != 0) begin
				req_ch.valid <= 1'b1;
				req_ch.data <= tick_q[0];
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// result monitor
	int unsigned   stall_left;
	ibb_pkg::rsp_t want;
	ibb_pkg::rsp_t got;

	task automatic note_field(input string fname, input logic [7:0] w, input logic [7:0] g);
		if (g !== w) begin
			n_err++;
			$display("%0t: %s mismatch, expected %0h actual %0h", $time, fname, w, g);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				got = rsp_ch.data;
				if (pins_due.size() == 0) begin
					n_err++;
					$display("%0t: unexpected result, expected none actual %p", $time, got);
				end else begin
					want = pins_due.pop_front();
					note_field("scl_out", want.scl_out, got.scl_out);
					note_field("sda_out", want.sda_out, got.sda_out);
					note_field("busy_res", want.busy_res, got.busy_res);
					note_field("done_res", want.done_res, got.done_res);
					note_field("read_data", want.read_data, got.read_data);
					note_field("ack_timeout", want.ack_timeout, got.ack_timeout);
				end
			end
			if (stall_left != 0) begin
				stall_left--;
				rsp_ch.ready <= 1'b0;
			end else if (idling && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(0, 9);
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// stimulus
	function automatic logic pick_sda(input sda_pol_t pol);
		case (pol)
			SDA_HIGH: return 1'b1;
			SDA_LOW:  return 1'b0;
			default:  return ($urandom_range(0, 3) != 0);
		endcase
	endfunction

	function automatic void push_tick(input logic [2:0] md, input logic [7:0] db, input logic s);
		ibb_pkg::req_t t;
		t.mode = md;
		t.data_byte = db;
		t.sda_in = s;
		tick_q.push_back(t);
		n_sent++;
	endfunction

	task automatic wait_accepted();
		do @(negedge clk); while (tick_q.size() != 0);
	endtask

	task automatic quiesce();
		do @(negedge clk); while (tick_q.size() != 0 || pins_due.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	// feed ticks until the engine copy goes idle; modes sent meanwhile are ignored
	task automatic settle(input sda_pol_t pol);
		int unsigned n;
		logic [2:0]  md;
		forever begin
			wait_accepted();
			if (m_ph == ibb_pkg::PH_IDLE)
				break;
			if (m_ph == ibb_pkg::PH_WA_POLL && m_dcnt == 0 && pol == SDA_HIGH)
				n = 32'(m_tl) - 32'(m_pcnt) + 1;
			else
				n = 32'(m_dcnt) + 1;
			repeat (n) begin
				md = ($urandom_range(0, 3) == 0) ? 3'($urandom) : MODE_NONE;
				push_tick(md, 8'($urandom), pick_sda(pol));
			end
		end
	endtask

	task automatic run_cmd(input logic [2:0] md, input logic [7:0] db, input sda_pol_t pol);
		push_tick(md, db, pick_sda(pol));
		settle(pol);
	endtask

	task automatic write_reg(input logic idx, input logic [ibb_pkg::CFG_W-1:0] val);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= ibb_pkg::cfg_t'{index: idx, value: val};
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		if (idx == ibb_pkg::REG_DELAY_UNIT)
			m_du = val;
		else
			m_tl = val;
		@(negedge clk);
	endtask

	initial begin
		logic [2:0] md;
		sda_pol_t   pol;

		req_ch.valid = 1'b0;
		req_ch.data  = '0;
		rsp_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data  = '0;
		arst_n = 1'b0;

		m_ph = ibb_pkg::PH_IDLE; m_bidx = '0; m_sreg = '0; m_dcnt = '0; m_pcnt = '0;
		m_scl = 1'b1; m_sda = 1'b1; m_last = '0; m_rd_ack = 1'b0; m_to = 1'b0;
		m_du = ibb_pkg::DELAY_UNIT_RST; m_tl = ibb_pkg::TIMEOUT_LIMIT_RST;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		// directed, reset settings
		run_cmd(ibb_pkg::MODE_START, 8'h00, SDA_RAND);
		run_cmd(ibb_pkg::MODE_WRITE, 8'hA5, SDA_RAND);
		run_cmd(ibb_pkg::MODE_READ_ACK, 8'h00, SDA_HIGH);
		run_cmd(ibb_pkg::MODE_READ_NACK, 8'h3C, SDA_LOW);
		run_cmd(ibb_pkg::MODE_WAIT_ACK, 8'hFF, SDA_LOW);
		push_tick(MODE_UNUSED, 8'hFF, 1'b1);
		push_tick(MODE_UNUSED, 8'h00, 1'b0);
		run_cmd(ibb_pkg::MODE_STOP, 8'h00, SDA_RAND);

		// zero timeout limit, then one
		quiesce();
		write_reg(ibb_pkg::REG_TIMEOUT_LIMIT, 16'd0);
		run_cmd(ibb_pkg::MODE_WAIT_ACK, 8'h00, SDA_HIGH);
		quiesce();
		write_reg(ibb_pkg::REG_TIMEOUT_LIMIT, 16'd1);
		run_cmd(ibb_pkg::MODE_WAIT_ACK, 8'h00, SDA_HIGH);

		// zero delay unit acts as one
		quiesce();
		write_reg(ibb_pkg::REG_DELAY_UNIT, 16'd0);
		run_cmd(ibb_pkg::MODE_START, 8'h00, SDA_RAND);
		run_cmd(ibb_pkg::MODE_WAIT_ACK, 8'h00, SDA_RAND);

		// random commands, the last stretch without idling
		for (int seg = 0; seg < 2; seg++) begin
			quiesce();
			if (seg == 1)
				idling = 1'b0;
			write_reg(ibb_pkg::REG_DELAY_UNIT, 16'($urandom_range(1, 2)));
			write_reg(ibb_pkg::REG_TIMEOUT_LIMIT, 16'($urandom_range(0, 3)));
			while (n_sent < ((seg == 0) ? 300 : 400)) begin
				if ($urandom_range(0, 3) == 0) begin
					repeat ($urandom_range(1, 3))
						push_tick($urandom_range(0, 1) ? MODE_UNUSED : MODE_NONE,
							8'($urandom), 1'($urandom));
				end
				md = 3'($urandom_range(1, 6));
				if (md == ibb_pkg::MODE_WAIT_ACK || $urandom_range(0, 4) == 0)
					pol = sda_pol_t'($urandom_range(0, 2));
				else
					pol = SDA_RAND;
				run_cmd(md, 8'($urandom), pol);
			end
		end

		quiesce();
		repeat (10) @(posedge clk);
		if (n_err == 0 && pins_due.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
